// File: rtl/tmcr_pkg.sv
// Package for the text-mode cell renderer.
// Holds the request codes, the fixed field widths and the memory control struct.
// It depends on nothing else.
`default_nettype none

package tmcr_pkg;

  localparam int REQ_W        = 2;
  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int ROW_W        = 4;
  localparam int FONT_W       = 8;
  localparam int COLOR_W      = 24;
  localparam int PIXELS_OUT   = 8;
  localparam int PALETTE_SIZE = 16;
  localparam int PAL_IDX_W    = 4;

  localparam logic [REQ_W-1:0] REQ_RENDER  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FONT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PALETTE = 2'd2;

  // Strobes from the pipeline control to the storage block.
  typedef struct packed {
    logic glyph_we;
    logic pal_we;
    logic rd_en;
  } tmcr_mem_ctl_t;

endpackage : tmcr_pkg

`default_nettype wire

// File: rtl/text_mode_cell_renderer.sv
// Top level of the text-mode cell renderer.
// Depends on tmcr_pkg and instantiates tmcr_store.
`default_nettype none

// The renderer takes one request per cycle on in_ unless stalled. A font write
// stores one glyph row, a palette write stores one RGB 8:8:8 color, and a
// render request turns one glyph row plus an attribute byte into eight pixels
// on the out_ channel, pixel_0 being the leftmost (font bit 0). Writes and
// unused request codes produce no output transfer. Sustained rate is one
// request per cycle while out_ready holds; a render result passes through
// the registered reads of the font memory and of the two palette read
// ports, then through the output register. Input and output are
// decoupled by that pipeline, so a new request is taken while a result waits
// as long as the read stage is free. Both memories come up undefined and
// need no clearing; a render must only use glyph rows and palette entries
// that were written before. A write followed by a render of the same entry
// in the next cycle sees the new data, since the write lands at the earlier
// edge. Characters or rows out of range render as all background, and
// pixels at or beyond GLYPH_WIDTH are driven to zero.
module text_mode_cell_renderer
  import tmcr_pkg::*;
#(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int CHAR_COUNT   = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [CHAR_W-1:0]  in_char_code,
  input  wire logic [ATTR_W-1:0]  in_attr_byte,
  input  wire logic [ROW_W-1:0]   in_glyph_row,
  input  wire logic               in_blink_hidden,
  input  wire logic [PAL_IDX_W-1:0] in_palette_index,
  input  wire logic [COLOR_W-1:0] in_write_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COLOR_W-1:0]      out_pixel_0,
  output logic [COLOR_W-1:0]      out_pixel_1,
  output logic [COLOR_W-1:0]      out_pixel_2,
  output logic [COLOR_W-1:0]      out_pixel_3,
  output logic [COLOR_W-1:0]      out_pixel_4,
  output logic [COLOR_W-1:0]      out_pixel_5,
  output logic [COLOR_W-1:0]      out_pixel_6,
  output logic [COLOR_W-1:0]      out_pixel_7
);

  localparam int GLYPH_DEPTH = CHAR_COUNT * GLYPH_HEIGHT;
  localparam int GADDR_W     = $clog2(GLYPH_DEPTH);
  // Wide enough for CHAR_COUNT * GLYPH_HEIGHT at their largest (4096).
  localparam int AMUL_W      = 13;
  localparam int RCMP_W      = 6;

  // Pipeline control. The output register moves when it is empty or taken;
  // the read stage moves when it is empty or the output register moves.
  logic out_valid_r, out_valid_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_in_range_r;
  logic out_en, s1_en, accept, is_render;

  assign out_en   = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_ready = s1_en;
  assign accept   = in_valid && in_ready;
  assign is_render = (in_req_type == REQ_RENDER);

  // Glyph address: char_code * GLYPH_HEIGHT + row, with a range check that
  // blocks font writes and blanks renders outside the font.
  logic              in_range;
  logic [AMUL_W-1:0] addr_full;
  logic [GADDR_W-1:0] glyph_addr;

  assign in_range = ({{(AMUL_W-CHAR_W){1'b0}}, in_char_code} < AMUL_W'(CHAR_COUNT)) &&
                    ({{(RCMP_W-ROW_W){1'b0}}, in_glyph_row} < RCMP_W'(GLYPH_HEIGHT));
  assign addr_full = {{(AMUL_W-CHAR_W){1'b0}}, in_char_code} * AMUL_W'(GLYPH_HEIGHT)
                   + {{(AMUL_W-ROW_W){1'b0}}, in_glyph_row};
  assign glyph_addr = addr_full[GADDR_W-1:0];

  // Color selection. The background index is attribute bits 6:4; a blinking
  // cell in its hidden phase paints its foreground in the background color.
  logic [PAL_IDX_W-1:0] fg_idx, bg_idx;

  assign bg_idx = {1'b0, in_attr_byte[6:4]};
  assign fg_idx = (in_attr_byte[7] && in_blink_hidden) ? bg_idx : in_attr_byte[3:0];

  tmcr_mem_ctl_t      mem_ctl;
  logic [FONT_W-1:0]  glyph_rdata_r;
  logic [COLOR_W-1:0] fg_color_r, bg_color_r;

  always_comb begin
    mem_ctl.glyph_we = accept && (in_req_type == REQ_FONT) && in_range;
    mem_ctl.pal_we   = accept && (in_req_type == REQ_PALETTE);
    mem_ctl.rd_en    = accept && is_render;
  end

  tmcr_store #(
    .GADDR_W     (GADDR_W),
    .GLYPH_DEPTH (GLYPH_DEPTH)
  ) u_store (
    .clk           (clk),
    .mem_ctl       (mem_ctl),
    .glyph_addr    (glyph_addr),
    .glyph_wdata   (in_write_data[FONT_W-1:0]),
    .pal_waddr     (in_palette_index),
    .pal_wdata     (in_write_data),
    .fg_idx        (fg_idx),
    .bg_idx        (bg_idx),
    .glyph_rdata_r (glyph_rdata_r),
    .fg_color_r    (fg_color_r),
    .bg_color_r    (bg_color_r)
  );

  // The read stage only holds a valid item for render requests; other
  // requests finish with their memory write.
  always_comb begin
    s1_valid_nxt  = s1_en ? (accept && is_render) : s1_valid_r;
    out_valid_nxt = out_en ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      s1_in_range_r <= in_range;
    end
  end

  // Pixel expansion into the output register. A row outside the font reads
  // as all clear, and columns past the glyph width stay zero.
  logic [FONT_W-1:0]  row_bits;
  logic [COLOR_W-1:0] pix_r   [PIXELS_OUT];
  logic [COLOR_W-1:0] pix_nxt [PIXELS_OUT];

  assign row_bits = s1_in_range_r ? glyph_rdata_r : '0;

  for (genvar k = 0; k < PIXELS_OUT; k++) begin : g_pix
    if (k < GLYPH_WIDTH) begin : g_used
      assign pix_nxt[k] = row_bits[k] ? fg_color_r : bg_color_r;
    end else begin : g_blank
      assign pix_nxt[k] = '0;
    end

    always_ff @(posedge clk) begin
      if (out_en && s1_valid_r) begin
        pix_r[k] <= pix_nxt[k];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_0 = pix_r[0];
  assign out_pixel_1 = pix_r[1];
  assign out_pixel_2 = pix_r[2];
  assign out_pixel_3 = pix_r[3];
  assign out_pixel_4 = pix_r[4];
  assign out_pixel_5 = pix_r[5];
  assign out_pixel_6 = pix_r[6];
  assign out_pixel_7 = pix_r[7];

`ifndef SYNTHESIS
  // Reset empties both pipeline stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // A render transfer always occupies the read stage in the next cycle.
  a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_render) |=> s1_valid_r)
    else $error("accepted render lost before read stage");

  // Writes and unused codes never create a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_render) |=> !s1_valid_r)
    else $error("non-render request produced a result");

  // An item in the read stage moves to the output whenever the output moves.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_en) |=> out_valid_r)
    else $error("read stage item dropped");

  // A single request never writes both memories.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.glyph_we && mem_ctl.pal_we))
    else $error("font and palette written together");
`endif

endmodule : text_mode_cell_renderer

`default_nettype wire

// File: rtl/tmcr_store.sv
// Font and palette memories of the text-mode cell renderer.
// Depends on tmcr_pkg for field widths and the control struct.
`default_nettype none

module tmcr_store
  import tmcr_pkg::*;
#(
  parameter int GADDR_W     = 12,
  parameter int GLYPH_DEPTH = 4096
) (
  input  wire logic                 clk,
  input  wire tmcr_mem_ctl_t        mem_ctl,
  input  wire logic [GADDR_W-1:0]   glyph_addr,
  input  wire logic [FONT_W-1:0]    glyph_wdata,
  input  wire logic [PAL_IDX_W-1:0] pal_waddr,
  input  wire logic [COLOR_W-1:0]   pal_wdata,
  input  wire logic [PAL_IDX_W-1:0] fg_idx,
  input  wire logic [PAL_IDX_W-1:0] bg_idx,
  output logic [FONT_W-1:0]         glyph_rdata_r,
  output logic [COLOR_W-1:0]        fg_color_r,
  output logic [COLOR_W-1:0]        bg_color_r
);

  logic [FONT_W-1:0]  glyph_mem [GLYPH_DEPTH];
  logic [COLOR_W-1:0] pal_mem   [PALETTE_SIZE];

  // Single-port font memory: a request either writes or reads it.
  always_ff @(posedge clk) begin
    if (mem_ctl.glyph_we) begin
      glyph_mem[glyph_addr] <= glyph_wdata;
    end
    if (mem_ctl.rd_en) begin
      glyph_rdata_r <= glyph_mem[glyph_addr];
    end
  end

  // Palette: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_ctl.pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
    if (mem_ctl.rd_en) begin
      fg_color_r <= pal_mem[fg_idx];
      bg_color_r <= pal_mem[bg_idx];
    end
  end

endmodule : tmcr_store

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text-mode cell renderer: a directed table, then random
// font writes, palette writes and renders under four idle and stall mixes.
// Depends on tmcr_pkg and the text_mode_cell_renderer RTL only.

module testbench;
  import tmcr_pkg::*;

  // Geometry of the instance. It is built with its default parameters, so these match.
  localparam int GLYPH_W    = 8;
  localparam int GLYPH_H    = 16;
  localparam int CHAR_N     = 256;
  localparam int FONT_DEPTH = CHAR_N * GLYPH_H;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  // The package names the three live request codes; the fourth is ignored by the block.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Attribute byte layout: foreground index in the low nibble, background index above
  // it, and the blink flag in the top bit.
  localparam int BLINK_BIT = 7;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int PHASES         = 4;
  localparam int DIRECTED_N     = 25;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;

  // Percentages per phase: no idling, a mostly idle sender, a mostly stalling receiver,
  // and both sides idling part of the time.
  localparam int SEND_IDLE  [PHASES] = '{0, 87, 0, 35};
  localparam int RECV_STALL [PHASES] = '{0, 0, 87, 35};

  // Eight pixels of one glyph row; element 0 is the leftmost pixel.
  typedef logic [PIXELS_OUT-1:0][COLOR_W-1:0] pixel_row_t;

  // One request as driven on the input channel. The last two fields never reach the
  // block: for directed rows whose result is obvious, the expected pixels are typed in.
  typedef struct packed {
    logic [REQ_W-1:0]     kind;
    logic [CHAR_W-1:0]    chr;
    logic [ATTR_W-1:0]    attr;
    logic [ROW_W-1:0]     row;
    logic                 hidden;
    logic [PAL_IDX_W-1:0] pidx;
    logic [COLOR_W-1:0]   data;
    logic                 typed;
    pixel_row_t           want;
  } cell_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  cell_req_t cur_req = '0;

  logic in_ready;
  logic out_valid;
  logic [COLOR_W-1:0] out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3;
  logic [COLOR_W-1:0] out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7;

  // Local copy of the block's two memories, plus a record of what has been written so
  // that renders only ever read glyph rows and colors that exist.
  logic [FONT_W-1:0]  font_mem [FONT_DEPTH];
  bit                 font_ok  [FONT_DEPTH];
  int                 font_addrs [$];
  int                 last_font_addr;
  logic [COLOR_W-1:0] pal_mem [PALETTE_SIZE];
  bit                 pal_ok  [PALETTE_SIZE];

  // Pixel rows still owed by the block, oldest first.
  pixel_row_t pending_rows [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int n_render = 0, n_font = 0, n_palette = 0, n_unused = 0, n_checked = 0;

  text_mode_cell_renderer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (cur_req.kind),
    .in_char_code     (cur_req.chr),
    .in_attr_byte     (cur_req.attr),
    .in_glyph_row     (cur_req.row),
    .in_blink_hidden  (cur_req.hidden),
    .in_palette_index (cur_req.pidx),
    .in_write_data    (cur_req.data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_0      (out_pixel_0),
    .out_pixel_1      (out_pixel_1),
    .out_pixel_2      (out_pixel_2),
    .out_pixel_3      (out_pixel_3),
    .out_pixel_4      (out_pixel_4),
    .out_pixel_5      (out_pixel_5),
    .out_pixel_6      (out_pixel_6),
    .out_pixel_7      (out_pixel_7)
  );

  always #CLK_HALF clk = ~clk;

  // The receiver decides at each falling edge whether it takes a result at the next
  // rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expected pixels for a render, from the current font and palette contents. A set font
  // bit takes the foreground color and a clear bit the background color. A blinking
  // attribute in its hidden phase paints the foreground in the background color. A
  // character or row outside the font renders as a blank row.
  function automatic pixel_row_t render_row(input cell_req_t r);
    logic [PAL_IDX_W-1:0] fg_idx;
    logic [PAL_IDX_W-1:0] bg_idx;
    logic [FONT_W-1:0]    bits;
    pixel_row_t           px;
    fg_idx = r.attr[3:0];
    bg_idx = {1'b0, r.attr[6:4]};
    if (r.attr[BLINK_BIT] && r.hidden) begin
      fg_idx = bg_idx;
    end
    bits = '0;
    if (int'(r.chr) < CHAR_N && int'(r.row) < GLYPH_H) begin
      bits = font_mem[FONT_AW'(int'(r.chr) * GLYPH_H + int'(r.row))];
    end
    for (int k = 0; k < PIXELS_OUT; k++) begin
      if (k >= GLYPH_W) begin
        px[k] = '0;
      end else begin
        px[k] = bits[k] ? pal_mem[fg_idx] : pal_mem[bg_idx];
      end
    end
    return px;
  endfunction

  // Both channels are sampled at the rising edge. A result transfer is checked against
  // the oldest pending row before the input transfer of the same edge is applied, so a
  // result can never be matched against a request that has only just gone in. Writes
  // update the local memories at once, which is what the block promises as well: a
  // render right after a write sees the new data.
  always @(posedge clk) begin
    pixel_row_t got;
    pixel_row_t want;
    int addr;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
               out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0};
        if (pending_rows.size() == 0) begin
          $error("result transfer with no render pending: pixel_0 = %06h", out_pixel_0);
          fail_count++;
        end else begin
          want = pending_rows.pop_front();
          n_checked++;
          for (int k = 0; k < PIXELS_OUT; k++) begin
            if (got[k] !== want[k]) begin
              $error("pixel_%0d: expected %06h, got %06h", k, want[k], got[k]);
              fail_count++;
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        case (cur_req.kind)
          REQ_RENDER: begin
            pending_rows.push_back(cur_req.typed ? cur_req.want : render_row(cur_req));
            n_render++;
          end
          REQ_FONT: begin
            // Writes outside the font are dropped by the block.
            if (int'(cur_req.chr) < CHAR_N && int'(cur_req.row) < GLYPH_H) begin
              addr = int'(cur_req.chr) * GLYPH_H + int'(cur_req.row);
              font_mem[FONT_AW'(addr)] = cur_req.data[FONT_W-1:0];
              if (!font_ok[FONT_AW'(addr)]) begin
                font_ok[FONT_AW'(addr)] = 1'b1;
                font_addrs.push_back(addr);
              end
              last_font_addr = addr;
            end
            n_font++;
          end
          REQ_PALETTE: begin
            pal_mem[cur_req.pidx] = cur_req.data;
            pal_ok[cur_req.pidx] = 1'b1;
            n_palette++;
          end
          default: begin
            n_unused++;
          end
        endcase
      end
    end
  end

  // Watchdog: a run that goes this long without any transfer on either channel is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d render results still pending",
               quiet_cycles, pending_rows.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one request, starting at a falling edge, and returns at the falling edge after
  // its transfer. Between requests the sender may go idle at random;
  // back to back, valid simply stays high while the payload moves on.
  task automatic send_request(input cell_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_req <= r;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Directed part. The palette gets a few well-known colors first (black, white, blue,
  // red and two alternating bit patterns) and a handful of glyph rows are stored; then
  // renders cover an all-set row, an all-clear row, a single pixel at each edge, blinking
  // in both phases, a hidden phase on a non-blinking attribute, an ignored request code
  // and a render that directly follows a write to the entry it reads.
  cell_req_t directed_reqs [DIRECTED_N] = '{
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd0,  24'h000000, 1'b0, '0},
    '{REQ_PALETTE, 8'hFF, 8'hFF, 4'hF, 1'b1, 4'd15, 24'hFFFFFF, 1'b0, '0},
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd7,  24'h0000FF, 1'b0, '0},
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd8,  24'hFF0000, 1'b0, '0},
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd1,  24'h555555, 1'b0, '0},
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd10, 24'hAAAAAA, 1'b0, '0},
    '{REQ_FONT,    8'h00, 8'h00, 4'h0, 1'b0, 4'd0,  24'h0000FF, 1'b0, '0},
    // Only the low byte is font data; the set bits above it must be ignored.
    '{REQ_FONT,    8'hFF, 8'hFF, 4'hF, 1'b1, 4'd15, 24'hFFFF00, 1'b0, '0},
    '{REQ_FONT,    8'h41, 8'h00, 4'h5, 1'b0, 4'd0,  24'h000001, 1'b0, '0},
    '{REQ_FONT,    8'h41, 8'h00, 4'h6, 1'b0, 4'd0,  24'h000080, 1'b0, '0},
    '{REQ_FONT,    8'hAA, 8'h00, 4'hA, 1'b0, 4'd0,  24'h000055, 1'b0, '0},
    '{REQ_UNUSED,  8'hFF, 8'hFF, 4'hF, 1'b1, 4'd15, 24'hFFFFFF, 1'b0, '0},
    '{REQ_RENDER,  8'h00, 8'h0F, 4'h0, 1'b0, 4'd15, 24'hFFFFFF, 1'b1, {8{24'hFFFFFF}}},
    '{REQ_RENDER,  8'hFF, 8'h0F, 4'hF, 1'b1, 4'd0,  24'h000000, 1'b1, {8{24'h000000}}},
    '{REQ_RENDER,  8'h41, 8'h78, 4'h5, 1'b0, 4'd0,  24'h000000, 1'b1,
      {{7{24'h0000FF}}, 24'hFF0000}},
    '{REQ_RENDER,  8'h41, 8'hF8, 4'h6, 1'b0, 4'd0,  24'h000000, 1'b1,
      {24'hFF0000, {7{24'h0000FF}}}},
    '{REQ_RENDER,  8'h41, 8'hF8, 4'h6, 1'b1, 4'd0,  24'h000000, 1'b1, {8{24'h0000FF}}},
    '{REQ_RENDER,  8'h41, 8'h8F, 4'h6, 1'b1, 4'd0,  24'h000000, 1'b1, {8{24'h000000}}},
    '{REQ_RENDER,  8'h41, 8'h8F, 4'h6, 1'b0, 4'd0,  24'h000000, 1'b1,
      {24'hFFFFFF, {7{24'h000000}}}},
    '{REQ_RENDER,  8'h00, 8'h7F, 4'h0, 1'b1, 4'd0,  24'h000000, 1'b1, {8{24'hFFFFFF}}},
    '{REQ_RENDER,  8'hAA, 8'h1A, 4'hA, 1'b0, 4'd0,  24'h000000, 1'b0, '0},
    '{REQ_PALETTE, 8'h00, 8'h00, 4'h0, 1'b0, 4'd15, 24'h00FF00, 1'b0, '0},
    '{REQ_RENDER,  8'h00, 8'h0F, 4'h0, 1'b0, 4'd0,  24'h000000, 1'b1, {8{24'h00FF00}}},
    '{REQ_FONT,    8'h00, 8'h00, 4'h0, 1'b0, 4'd0,  24'h00003C, 1'b0, '0},
    '{REQ_RENDER,  8'h00, 8'h1F, 4'h0, 1'b0, 4'd0,  24'h000000, 1'b0, '0}
  };

  initial begin
    cell_req_t r;
    int pick;
    int sent;
    int addr;
    int fg;
    int bg;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];

      if (ph == 0) begin
        for (int i = 0; i < DIRECTED_N; i++) begin
          send_request(directed_reqs[i]);
        end
      end

      // Random traffic. Fields that the request does not use are random as well, so the
      // block must ignore them. Renders read only written glyph rows and colors; one in
      // five reads the row written last, which often lands right behind its write.
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        r.kind   = REQ_UNUSED;
        r.chr    = CHAR_W'($urandom_range(255));
        r.attr   = ATTR_W'($urandom_range(255));
        r.row    = ROW_W'($urandom_range(15));
        r.hidden = 1'($urandom_range(1));
        r.pidx   = PAL_IDX_W'($urandom_range(PALETTE_SIZE - 1));
        r.data   = COLOR_W'($urandom_range(24'hFFFFFF));
        r.typed  = 1'b0;
        r.want   = '0;
        pick = $urandom_range(99);
        if (pick < 55) begin
          if ($urandom_range(4) == 0) begin
            addr = last_font_addr;
          end else begin
            addr = font_addrs[$urandom_range(font_addrs.size() - 1)];
          end
          do fg = $urandom_range(PALETTE_SIZE - 1); while (!pal_ok[PAL_IDX_W'(fg)]);
          do bg = $urandom_range(7); while (!pal_ok[PAL_IDX_W'(bg)]);
          r.kind = REQ_RENDER;
          r.chr  = CHAR_W'(addr / GLYPH_H);
          r.row  = ROW_W'(addr % GLYPH_H);
          r.attr = {$urandom_range(1) == 1, bg[2:0], fg[3:0]};
          sent++;
        end else if (pick < 80) begin
          // Mostly fresh rows so the font fills up, sometimes an overwrite.
          if ($urandom_range(9) < 3) begin
            addr = font_addrs[$urandom_range(font_addrs.size() - 1)];
          end else begin
            addr = $urandom_range(FONT_DEPTH - 1);
          end
          r.kind = REQ_FONT;
          r.chr  = CHAR_W'(addr / GLYPH_H);
          r.row  = ROW_W'(addr % GLYPH_H);
          sent++;
        end else if (pick < 92) begin
          r.kind = REQ_PALETTE;
          sent++;
        end
        send_request(r);
      end
    end

    in_valid <= 1'b0;
    while (pending_rows.size() != 0) begin
      @(negedge clk);
    end
    // Let any stray result that the pipeline might still emit show up and be flagged.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d rendered rows; also sent %0d font writes, %0d palette writes",
             n_checked, n_render, n_font, n_palette);
    $display("and %0d unused request codes across four sender and receiver idle mixes.",
             n_unused);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
